@@ hw/rtl/lse_pkg.sv @@
`timescale 1ns / 1ps

package lse_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int HDR_W = 10;
	localparam int LEN_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [HDR_W-1:0] HEADER_BYTES_RST = 10'd54;
	localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 32'd10000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE_SELECT    = 2'd0,
		CFG_HEADER_BYTES   = 2'd1,
		CFG_MESSAGE_LENGTH = 2'd2,
		CFG_MAX_LENGTH     = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_OVER_LIMIT = 2'd1,
		STATUS_UNDERRUN   = 2'd2
	} status_t;

	typedef enum logic {
		MODE_EMBED   = 1'b0,
		MODE_EXTRACT = 1'b1
	} mode_t;

	typedef struct packed {
		logic [7:0] image_byte;
		logic [7:0] message_byte;
		logic       start_of_image;
		logic       end_of_image;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] recovered_byte;
		logic       recovered_valid;
		logic       need_message_byte;
		logic       payload_done;
		status_t    status;
	} out_item_t;

	typedef struct packed {
		mode_t            mode_select;
		logic [HDR_W-1:0] header_bytes;
		logic [LEN_W-1:0] message_length;
		logic [LEN_W-1:0] max_length;
	} cfg_regs_t;

endpackage

@@ hw/rtl/lse_cfg_regs.sv @@
`timescale 1ns / 1ps

module lse_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lse_pkg::LEN_W-1:0] cfg_data,
	output lse_pkg::cfg_regs_t        cfg
);
	import lse_pkg::*;

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.mode_select    <= MODE_EMBED;
			regs_q.header_bytes   <= HEADER_BYTES_RST;
			regs_q.message_length <= '0;
			regs_q.max_length     <= MAX_LENGTH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_MODE_SELECT:    regs_q.mode_select    <= mode_t'(cfg_data[0]);
				CFG_HEADER_BYTES:   regs_q.header_bytes   <= cfg_data[HDR_W-1:0];
				CFG_MESSAGE_LENGTH: regs_q.message_length <= cfg_data;
				CFG_MAX_LENGTH:     regs_q.max_length     <= cfg_data;
			endcase
		end
	end

endmodule

@@ hw/rtl/lse_core.sv @@
`timescale 1ns / 1ps

module lse_core #(
	parameter int LENGTH_BITS = lse_pkg::LENGTH_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lse_pkg::cfg_regs_t cfg,
	input  logic               item_valid_s1,
	input  lse_pkg::in_item_t  item_s1,
	output logic               take,
	output logic               out_valid,
	input  logic               out_ready,
	output lse_pkg::out_item_t out_data
);
	import lse_pkg::*;

	localparam int CNT_W = $clog2(LENGTH_BITS + 1);
	localparam int IDX_W = $clog2(LENGTH_BITS);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LENGTH_BITS);
	localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(LENGTH_BITS - 1);

	logic [HDR_W-1:0]       header_count_q, header_count_c, header_count_n;
	logic [CNT_W-1:0]       length_bit_count_q, length_bit_count_c, length_bit_count_n;
	logic [LENGTH_BITS-1:0] length_shift_q, length_shift_c, length_shift_n;
	logic [2:0]             bit_in_byte_q, bit_in_byte_c, bit_in_byte_n;
	logic [7:0]             byte_shift_q, byte_shift_c, byte_shift_n;
	logic [LEN_W-1:0]       bytes_done_q, bytes_done_c, bytes_done_n;
	status_t                error_state_q, error_state_c, error_state_n;

	logic [LENGTH_BITS-1:0] msg_len;
	logic [LEN_W-1:0]       target_c, target_n;
	logic [IDX_W-1:0]       len_idx;
	logic [7:0]             src_byte;
	logic                   lsb;
	logic                   done;
	out_item_t              res;

	logic      out_valid_s2;
	out_item_t out_data_s2;

	assign take      = item_valid_s1 && (!out_valid_s2 || out_ready);
	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

	assign msg_len = cfg.message_length[LENGTH_BITS-1:0];
	assign lsb     = item_s1.image_byte[0];
	assign len_idx = IDX_TOP - length_bit_count_c[IDX_W-1:0];

	// start of image clears the counters before the byte is handled
	always_comb begin
		if (item_s1.start_of_image) begin
			header_count_c     = '0;
			length_bit_count_c = '0;
			length_shift_c     = '0;
			bit_in_byte_c      = '0;
			byte_shift_c       = '0;
			bytes_done_c       = '0;
			error_state_c      = STATUS_OK;
		end else begin
			header_count_c     = header_count_q;
			length_bit_count_c = length_bit_count_q;
			length_shift_c     = length_shift_q;
			bit_in_byte_c      = bit_in_byte_q;
			byte_shift_c       = byte_shift_q;
			bytes_done_c       = bytes_done_q;
			error_state_c      = error_state_q;
		end
	end

	assign target_c = (cfg.mode_select == MODE_EXTRACT) ? LEN_W'(length_shift_c)
		: LEN_W'(msg_len);
	assign target_n = (cfg.mode_select == MODE_EXTRACT) ? LEN_W'(length_shift_n)
		: LEN_W'(msg_len);
	assign src_byte = (bit_in_byte_c == 3'd0) ? item_s1.message_byte : byte_shift_c;

	always_comb begin
		header_count_n     = header_count_c;
		length_bit_count_n = length_bit_count_c;
		length_shift_n     = length_shift_c;
		bit_in_byte_n      = bit_in_byte_c;
		byte_shift_n       = byte_shift_c;
		bytes_done_n       = bytes_done_c;
		error_state_n      = error_state_c;
		res.out_byte          = item_s1.image_byte;
		res.recovered_byte    = 8'd0;
		res.recovered_valid   = 1'b0;
		res.need_message_byte = 1'b0;

		priority if (header_count_c < cfg.header_bytes) begin
			header_count_n = header_count_c + HDR_W'(1);
		end else if (error_state_c == STATUS_OVER_LIMIT) begin
			// rejected length: pass the rest through
		end else if (length_bit_count_c < CNT_FULL) begin
			if (cfg.mode_select == MODE_EMBED) begin
				res.out_byte = {item_s1.image_byte[7:1], msg_len[len_idx]};
			end else begin
				length_shift_n = {length_shift_c[LENGTH_BITS-2:0], lsb};
			end
			length_bit_count_n = length_bit_count_c + CNT_W'(1);
			if (length_bit_count_n == CNT_FULL && cfg.mode_select == MODE_EXTRACT
					&& LEN_W'(length_shift_n) > cfg.max_length) begin
				error_state_n = STATUS_OVER_LIMIT;
			end
		end else if (bytes_done_c < target_c) begin
			bit_in_byte_n = bit_in_byte_c + 3'd1;
			if (cfg.mode_select == MODE_EMBED) begin
				byte_shift_n = src_byte;
				res.need_message_byte = (bit_in_byte_c == 3'd0);
				res.out_byte = {item_s1.image_byte[7:1], src_byte[~bit_in_byte_c]};
				if (bit_in_byte_n == 3'd0) begin
					bytes_done_n = bytes_done_c + LEN_W'(1);
				end
			end else begin
				byte_shift_n = {byte_shift_c[6:0], lsb};
				if (bit_in_byte_n == 3'd0) begin
					res.recovered_byte  = byte_shift_n;
					res.recovered_valid = 1'b1;
					bytes_done_n = bytes_done_c + LEN_W'(1);
				end
			end
		end else begin
			// payload finished: pass through
		end

		done = (error_state_n != STATUS_OVER_LIMIT) && (length_bit_count_n >= CNT_FULL)
			&& (bytes_done_n >= target_n);
		if (item_s1.end_of_image && !done && error_state_n == STATUS_OK) begin
			error_state_n = STATUS_UNDERRUN;
		end
		res.payload_done = done;
		res.status       = error_state_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q     <= '0;
			length_bit_count_q <= '0;
			length_shift_q     <= '0;
			bit_in_byte_q      <= '0;
			byte_shift_q       <= '0;
			bytes_done_q       <= '0;
			error_state_q      <= STATUS_OK;
		end else if (take) begin
			header_count_q     <= header_count_n;
			length_bit_count_q <= length_bit_count_n;
			length_shift_q     <= length_shift_n;
			bit_in_byte_q      <= bit_in_byte_n;
			byte_shift_q       <= byte_shift_n;
			bytes_done_q       <= bytes_done_n;
			error_state_q      <= error_state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (take) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_s2 <= res;
		end
	end

endmodule

@@ hw/rtl/lsb_stego_embed_extract.sv @@
`timescale 1ns / 1ps
// A byte passes through the input register, then the result register, before it leaves;
// a stall on out_ready holds it in either register.
// Throughput: one image byte per cycle; the per-image counters update in the single
// pass between the two registers, so a new byte is taken every cycle while the output drains.
// Reset (arst_n low): registers return to their defaults, counters and status clear,
// both pipeline stages empty.
module lsb_stego_embed_extract #(
	parameter int LENGTH_BITS = lse_pkg::LENGTH_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lse_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lse_pkg::out_item_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lse_pkg::LEN_W-1:0]     cfg_data
);
	import lse_pkg::*;

	cfg_regs_t cfg;
	logic      item_valid_s1;
	in_item_t  item_s1;
	logic      take;

	lse_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign in_ready = !item_valid_s1 || take;

	// hold the byte until the core moves it into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	lse_core #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.take          (take),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data)
	);

endmodule
